// ----- rtl/core/isosurface_cell_detector_assert.svh -----
// Assertion macros for the isosurface cell detector checker.
// Depends on nothing; included by the checker file only.
`ifndef ISOSURFACE_CELL_DETECTOR_ASSERT_SVH
`define ISOSURFACE_CELL_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ISC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/isc_pkg.sv -----
// Shared types, constants and helpers of the isosurface cell detector.
// Used by isc_cell, isc_chain and the top level; depends on nothing.
package isc_pkg;

    localparam int unsigned LEVEL_W    = 17;
    localparam int unsigned DIM_W      = 7;
    localparam int unsigned COORD_W    = 6;
    localparam int unsigned CELL_DEPTH = 64;
    localparam int unsigned SLOT_W     = 6;
    localparam int unsigned BANK_DEPTH = CELL_DEPTH / 2;
    localparam int unsigned BANK_AW    = SLOT_W - 1;

    localparam logic [DIM_W-1:0] DIM_RST = 7'd64;
    localparam logic [DIM_W-1:0] DIM_MIN = 7'd2;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [SLOT_W-1:0] t_slot;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LEVEL = 2'd0,
        CFG_DIM_X = 2'd1,
        CFG_DIM_Y = 2'd2,
        CFG_DIM_Z = 2'd3
    } t_cfg_idx;

    // Control broadcast from a chain to each of its cells.
    typedef struct packed {
        logic                en;
        t_slot               wr_slot;
        t_slot               hand_slot;
        logic [BANK_AW-1:0]  tap_even;
        logic [BANK_AW-1:0]  tap_odd;
    } t_cell_ctrl;

    // Clamp a dimension register into [2, maxv].
    function automatic t_dim f_clamp(t_dim d, int unsigned maxv);
        t_dim res;
        res = d;
        if (d < DIM_MIN) begin
            res = DIM_MIN;
        end else if (int'(d) > int'(maxv)) begin
            res = DIM_W'(maxv);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/isc_cell.sv -----
// One cell of the compare-bit delay chain: 64 bit slots in an even and an odd bank.
// Depends on isc_pkg; instantiated by isc_chain.
module isc_cell
    import isc_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_din,
    output logic       o_hand,
    output logic       o_tap_even,
    output logic       o_tap_odd
);

    logic               r_mem_even [BANK_DEPTH];
    logic               r_mem_odd  [BANK_DEPTH];
    logic               r_hand_even;
    logic               r_hand_odd;
    logic               r_hand_sel;
    logic               r_tap_even;
    logic               r_tap_odd;
    logic [BANK_AW-1:0] wr_addr;
    logic [BANK_AW-1:0] hand_addr;

    assign wr_addr   = i_ctrl.wr_slot[SLOT_W-1:1];
    assign hand_addr = i_ctrl.hand_slot[SLOT_W-1:1];

    // Even bank: write the slot under the pointer, read the handoff and tap slots.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            if (!i_ctrl.wr_slot[0]) begin
                r_mem_even[wr_addr] <= i_din;
            end
            r_hand_even <= r_mem_even[hand_addr];
            r_tap_even  <= r_mem_even[i_ctrl.tap_even];
        end
    end

    // Odd bank, same ports.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            if (i_ctrl.wr_slot[0]) begin
                r_mem_odd[wr_addr] <= i_din;
            end
            r_hand_odd <= r_mem_odd[hand_addr];
            r_tap_odd  <= r_mem_odd[i_ctrl.tap_odd];
        end
    end

    // The oldest bit leaves toward the next cell from whichever bank held it.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_hand_sel <= i_ctrl.hand_slot[0];
        end
    end

    assign o_hand     = r_hand_sel ? r_hand_odd : r_hand_even;
    assign o_tap_even = r_tap_even;
    assign o_tap_odd  = r_tap_odd;

endmodule

// ----- rtl/core/isc_chain.sv -----
// Row of delay cells holding the compare-bit history, read at two adjacent ages.
// Depends on isc_pkg and isc_cell; instantiated three times by the top level.
module isc_chain
    import isc_pkg::*;
#(
    parameter int unsigned AGES = 65
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_slot                      i_ptr,
    input  logic [$clog2(AGES+1)-1:0]  i_age,
    input  logic                       i_bit,
    output logic                       o_bit_k,
    output logic                       o_bit_k1
);

    localparam int unsigned AW    = $clog2(AGES + 1);
    localparam int unsigned NCELL = (AGES + CELL_DEPTH - 1) / CELL_DEPTH;
    localparam int unsigned CW    = (NCELL > 1) ? $clog2(NCELL) : 1;

    logic [AW+SLOT_W-1:0] age_w;
    logic [AW+SLOT_W-1:0] km1_w;
    t_slot                off;
    t_slot                slot_k;
    t_slot                slot_k1;
    logic [CW-1:0]        cell_k;
    logic [CW-1:0]        cell_k1;
    t_cell_ctrl           ctrl;
    logic [CW-1:0]        r_cell_k;
    logic [CW-1:0]        r_cell_k1;
    logic                 r_k_odd;
    logic                 hand     [NCELL];
    logic                 tap_even [NCELL];
    logic                 tap_odd  [NCELL];

    // Age k sits in cell (k-1)/64, written (k-1)%64+1 beats ago.
    assign age_w   = (AW + SLOT_W)'(i_age);
    assign km1_w   = age_w - (AW + SLOT_W)'(1);
    assign off     = km1_w[SLOT_W-1:0];
    assign slot_k  = i_ptr - off - SLOT_W'(1);
    assign slot_k1 = slot_k - SLOT_W'(1);
    assign cell_k  = CW'(km1_w >> SLOT_W);
    assign cell_k1 = CW'(age_w >> SLOT_W);

    // Adjacent ages always fall in opposite banks.
    always_comb begin
        ctrl.en        = i_en;
        ctrl.wr_slot   = i_ptr;
        ctrl.hand_slot = i_ptr + SLOT_W'(1);
        if (slot_k[0]) begin
            ctrl.tap_odd  = slot_k[SLOT_W-1:1];
            ctrl.tap_even = slot_k1[SLOT_W-1:1];
        end else begin
            ctrl.tap_even = slot_k[SLOT_W-1:1];
            ctrl.tap_odd  = slot_k1[SLOT_W-1:1];
        end
    end

    // Remember which cells and banks the registered tap data came from.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell_k  <= cell_k;
            r_cell_k1 <= cell_k1;
            r_k_odd   <= slot_k[0];
        end
    end

    // The cells, each fed by the handoff of its left neighbor.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic din;
        if (g == 0) begin : g_head
            assign din = i_bit;
        end else begin : g_body
            assign din = hand[g-1];
        end
        isc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_din      (din),
            .o_hand     (hand[g]),
            .o_tap_even (tap_even[g]),
            .o_tap_odd  (tap_odd[g])
        );
    end

    assign o_bit_k  = r_k_odd ? tap_odd[r_cell_k]   : tap_even[r_cell_k];
    assign o_bit_k1 = r_k_odd ? tap_even[r_cell_k1] : tap_odd[r_cell_k1];

endmodule

// ----- rtl/core/isosurface_cell_detector.sv -----
// A result beat leaves through stage one and then the output register after the input beat that closes its cube.
// Throughput: one voxel beat per cycle unless output stalls; one tap read per bank.
// Reset (synchronous, active low) clears positions, history pointer, configuration
// and valid flags; the delay cells are not cleared and hold garbage until written.
// Depends on isc_pkg and isc_chain.
module isosurface_cell_detector
    import isc_pkg::*;
#(
    parameter int unsigned MAX_X = 64,
    parameter int unsigned MAX_Y = 64,
    parameter int unsigned MAX_Z = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [LEVEL_W-1:0] i_cfg_data,
    // voxel input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [LEVEL_W-1:0] i_sample,
    input  logic               i_start_of_volume,
    // cell output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic [COORD_W-1:0] o_cell_z
);

    localparam int unsigned AGES_A = MAX_Z + 1;
    localparam int unsigned AGES_B = MAX_Y * MAX_Z + 1;
    localparam int unsigned AGES_C = MAX_Y * MAX_Z + MAX_Z + 1;
    localparam int unsigned AWA    = $clog2(AGES_A + 1);
    localparam int unsigned AWB    = $clog2(AGES_B + 1);
    localparam int unsigned AWC    = $clog2(AGES_C + 1);
    localparam int unsigned PROD_W = 2 * DIM_W;
    localparam logic [PROD_W-1:0] PLANE_RST =
        PROD_W'(f_clamp(DIM_RST, MAX_Y)) * PROD_W'(f_clamp(DIM_RST, MAX_Z));

    // Configuration registers and the plane size derived from them.
    logic [LEVEL_W-1:0] r_level, n_level;
    t_dim               r_dim_x, n_dim_x;
    t_dim               r_dim_y, n_dim_y;
    t_dim               r_dim_z, n_dim_z;
    logic [AWB-1:0]     r_plane, n_plane;
    t_dim               cfg_dim;
    logic [PROD_W-1:0]  cfg_prod;

    assign cfg_dim = i_cfg_data[DIM_W-1:0];

    always_comb begin
        n_level  = r_level;
        n_dim_x  = r_dim_x;
        n_dim_y  = r_dim_y;
        n_dim_z  = r_dim_z;
        cfg_prod = PROD_W'(f_clamp(r_dim_y, MAX_Y)) * PROD_W'(f_clamp(r_dim_z, MAX_Z));
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEVEL: begin
                    n_level = i_cfg_data;
                end
                CFG_DIM_X: begin
                    n_dim_x = cfg_dim;
                end
                CFG_DIM_Y: begin
                    n_dim_y  = cfg_dim;
                    cfg_prod = PROD_W'(f_clamp(cfg_dim, MAX_Y))
                             * PROD_W'(f_clamp(r_dim_z, MAX_Z));
                end
                CFG_DIM_Z: begin
                    n_dim_z  = cfg_dim;
                    cfg_prod = PROD_W'(f_clamp(r_dim_y, MAX_Y))
                             * PROD_W'(f_clamp(cfg_dim, MAX_Z));
                end
                default: begin
                    n_level = r_level;
                end
            endcase
        end
        n_plane = AWB'(cfg_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_dim_x <= DIM_RST;
            r_dim_y <= DIM_RST;
            r_dim_z <= DIM_RST;
            r_plane <= AWB'(PLANE_RST);
        end else begin
            r_level <= n_level;
            r_dim_x <= n_dim_x;
            r_dim_y <= n_dim_y;
            r_dim_z <= n_dim_z;
            r_plane <= n_plane;
        end
    end

    // Handshake: stage one empties into the output register or drops a non-crossing voxel.
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_hit;
    logic s1_adv;
    logic out_free;
    logic accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!s1_hit || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // Position of the current voxel and its successor.
    t_dim dx, dy, dz;
    t_dim r_pos_x, n_pos_x;
    t_dim r_pos_y, n_pos_y;
    t_dim r_pos_z, n_pos_z;
    t_dim cx, cy, cz;
    logic cur_bit;
    logic inner;

    assign dx      = f_clamp(r_dim_x, MAX_X);
    assign dy      = f_clamp(r_dim_y, MAX_Y);
    assign dz      = f_clamp(r_dim_z, MAX_Z);
    assign cx      = i_start_of_volume ? '0 : r_pos_x;
    assign cy      = i_start_of_volume ? '0 : r_pos_y;
    assign cz      = i_start_of_volume ? '0 : r_pos_z;
    assign cur_bit = i_sample > r_level;
    assign inner   = (cx != '0) && (cy != '0) && (cz != '0);

    // Raster advance; a counter at or past its last index wraps and carries.
    always_comb begin
        n_pos_x = cx;
        n_pos_y = cy;
        n_pos_z = cz + DIM_W'(1);
        if (cz >= dz - DIM_W'(1)) begin
            n_pos_z = '0;
            n_pos_y = cy + DIM_W'(1);
            if (cy >= dy - DIM_W'(1)) begin
                n_pos_y = '0;
                n_pos_x = (cx >= dx - DIM_W'(1)) ? '0 : cx + DIM_W'(1);
            end
        end
    end

    // History pointer and control state.
    t_slot r_ptr;
    logic  r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_ptr   <= '0;
        end else if (accept) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_ptr   <= r_ptr + SLOT_W'(1);
        end
    end

    // Corner ages of the cube closed by the current voxel.
    logic [AWA-1:0] age_a;
    logic [AWB-1:0] age_b;
    logic [AWC-1:0] age_c;
    logic           bit_a0, bit_a1, bit_b0, bit_b1, bit_c0, bit_c1;

    assign age_a = AWA'(dz);
    assign age_b = r_plane;
    assign age_c = AWC'(r_plane) + AWC'(dz);

    // Previous row: ages dz and dz+1.
    isc_chain #(.AGES(AGES_A)) u_chain_row (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_ptr    (r_ptr),
        .i_age    (age_a),
        .i_bit    (cur_bit),
        .o_bit_k  (bit_a0),
        .o_bit_k1 (bit_a1)
    );

    // Previous plane: ages plane and plane+1.
    isc_chain #(.AGES(AGES_B)) u_chain_plane (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_ptr    (r_ptr),
        .i_age    (age_b),
        .i_bit    (cur_bit),
        .o_bit_k  (bit_b0),
        .o_bit_k1 (bit_b1)
    );

    // Previous plane and row: ages plane+dz and plane+dz+1.
    isc_chain #(.AGES(AGES_C)) u_chain_diag (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_ptr    (r_ptr),
        .i_age    (age_c),
        .i_bit    (cur_bit),
        .o_bit_k  (bit_c0),
        .o_bit_k1 (bit_c1)
    );

    // Stage one holds the voxel while its tap bits come out of the cells.
    logic               r_s1_inner;
    logic               r_s1_bit;
    logic               r_s1_prev;
    logic [COORD_W-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic [7:0]         corners;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev     <= cur_bit;
            r_s1_prev  <= r_prev;
            r_s1_bit   <= cur_bit;
            r_s1_inner <= inner;
            r_s1_x     <= COORD_W'(cx - DIM_W'(1));
            r_s1_y     <= COORD_W'(cy - DIM_W'(1));
            r_s1_z     <= COORD_W'(cz - DIM_W'(1));
        end
    end

    // A cube crosses the level when its corners are neither all above nor all below.
    assign corners = {r_s1_bit, r_s1_prev, bit_a0, bit_a1, bit_b0, bit_b1, bit_c0, bit_c1};
    assign s1_hit  = r_s1_valid && r_s1_inner && (|corners) && !(&corners);

    // Output register.
    logic [COORD_W-1:0] r_out_x, r_out_y, r_out_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_hit) begin
            r_out_x <= r_s1_x;
            r_out_y <= r_s1_y;
            r_out_z <= r_s1_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_cell_z    = r_out_z;

endmodule

// ----- rtl/core/isc_checker.sv -----
// Port-level checker for the isosurface cell detector, bound to the top level.
// Depends on isc_pkg and isosurface_cell_detector_assert.svh.
`include "isosurface_cell_detector_assert.svh"

module isc_checker
    import isc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_cell_x,
    input logic [COORD_W-1:0] o_cell_y,
    input logic [COORD_W-1:0] o_cell_z
);

    logic out_stall;
    logic in_beat;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_beat   = i_in_valid && o_in_ready;

    // A result beat that is not taken stays offered.
    `ISC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid, "result beat dropped")

    // A stalled result beat keeps its coordinates.
    `ISC_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable({o_cell_x, o_cell_y, o_cell_z}), "result beat changed")

    // Reset empties the output.
    `ISC_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid, "result beat after reset")

    // A fresh result beat must follow an accepted input beat.
    `ISC_ASSERT_IMP(a_rise_src, i_clk, i_rst_n, $rose(o_out_valid), $past(in_beat, 2), "result beat without source")

endmodule

bind isosurface_cell_detector isc_checker u_isc_checker (.*);
